/* design/mpl_pkg.sv */
// Shared constants for the mesh point locator.
package mpl_pkg;
  localparam int unsigned MaxTriangles = 256;
  localparam int unsigned CoordBits    = 24;
  localparam int unsigned CntBits      = 9;
  localparam int unsigned TolMul       = 41;
  localparam int unsigned TolShift     = 13;
  localparam logic        ReqLoad      = 1'b0;
  localparam logic        ReqQuery     = 1'b1;
  localparam logic [1:0]  CornerMid    = 2'd3;
endpackage

/* design/mpl_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
module mpl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/mpl_front.sv */
// Front end: take requests, hold them in a two-entry queue for the back end.
module mpl_front #(
  parameter int unsigned CoordBits = mpl_pkg::CoordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 req_type_i,
  input  logic [7:0]           tri_index_i,
  input  logic [1:0]           corner_i,
  input  logic [CoordBits-1:0] pos_x_i,
  input  logic [CoordBits-1:0] pos_y_i,
  input  logic [CoordBits-1:0] pos_z_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output logic [3*CoordBits+10:0] q_data_o
);
  localparam int unsigned DW = 3 * CoordBits + 11;
  logic [DW-1:0] ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = ent_q[rd_q];

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i && q_valid_o) cnt_d = cnt_q - 2'd1;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i && q_valid_o) rd_q <= ~rd_q;
    end
  end

  // Store request payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= {req_type_i, tri_index_i, corner_i, pos_x_i, pos_y_i, pos_z_i};
    end
  end
endmodule

/* design/mpl_back.sv */
// Back end: perform loads and scan the triangle table for queries.
module mpl_back #(
  parameter int unsigned MaxTriangles = mpl_pkg::MaxTriangles,
  parameter int unsigned CoordBits    = mpl_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mpl_pkg::CntBits-1:0] active_q_i,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  logic [3*CoordBits+10:0]     q_data_i,
  output logic                        done_o,
  output logic                        inside_found_o,
  output logic [7:0]                  inside_index_o,
  output logic                        nearest_found_o,
  output logic [7:0]                  nearest_index_o
);
  localparam int unsigned C  = CoordBits;
  localparam int unsigned AW = (MaxTriangles > 1) ? $clog2(MaxTriangles) : 1;
  localparam int unsigned VW = 2 * C;
  localparam int unsigned MW = 3 * C;
  localparam int unsigned DW = C + 2;      // difference width
  localparam int unsigned PW = 2 * DW;     // product width
  localparam int unsigned SW = PW + 3;     // area sum width
  localparam int unsigned QW = 2 * C + 4;  // squared distance width
  localparam logic [1:0]  StIdle = 2'd0;
  localparam logic [1:0]  StScan = 2'd1;
  localparam logic [1:0]  StDrain = 2'd2;

  // Unpack request
  logic          rq_type;
  logic [7:0]    rq_tri;
  logic [1:0]    rq_corner;
  logic signed [C-1:0] rq_x, rq_y, rq_z;
  assign {rq_type, rq_tri, rq_corner, rq_x, rq_y, rq_z} = q_data_i;

  logic [1:0]    st_q, st_d;
  logic [16:0]   n_q, n_d;
  logic [16:0]   rd_cnt_q, rd_cnt_d;
  logic          s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [AW-1:0] s1_i_q, s2_i_q, s3_i_q, s4_i_q;
  logic signed [C-1:0] px_q, py_q, pz_q;
  logic          load_ok;
  logic          we_v0, we_v1, we_v2, we_m;
  logic [AW-1:0] raddr;
  logic [VW-1:0] v0_rd, v1_rd, v2_rd;
  logic [MW-1:0] m_rd;

  assign load_ok = (32'(rq_tri) < MaxTriangles);
  assign q_pop_o = q_valid_i && (st_q == StIdle);
  assign we_v0 = q_pop_o && rq_type == mpl_pkg::ReqLoad && load_ok && rq_corner == 2'd0;
  assign we_v1 = q_pop_o && rq_type == mpl_pkg::ReqLoad && load_ok && rq_corner == 2'd1;
  assign we_v2 = q_pop_o && rq_type == mpl_pkg::ReqLoad && load_ok && rq_corner == 2'd2;
  assign we_m  = q_pop_o && rq_type == mpl_pkg::ReqLoad && load_ok &&
                 rq_corner == mpl_pkg::CornerMid;
  assign raddr = rd_cnt_q[AW-1:0];

  mpl_ram #(.Width(VW), .Depth(MaxTriangles)) u_v0 (.clk_i, .we_i(we_v0),
    .waddr_i(rq_tri[AW-1:0]), .wdata_i({rq_x, rq_z}), .raddr_i(raddr), .rdata_o(v0_rd));
  mpl_ram #(.Width(VW), .Depth(MaxTriangles)) u_v1 (.clk_i, .we_i(we_v1),
    .waddr_i(rq_tri[AW-1:0]), .wdata_i({rq_x, rq_z}), .raddr_i(raddr), .rdata_o(v1_rd));
  mpl_ram #(.Width(VW), .Depth(MaxTriangles)) u_v2 (.clk_i, .we_i(we_v2),
    .waddr_i(rq_tri[AW-1:0]), .wdata_i({rq_x, rq_z}), .raddr_i(raddr), .rdata_o(v2_rd));
  mpl_ram #(.Width(MW), .Depth(MaxTriangles)) u_mid (.clk_i, .we_i(we_m),
    .waddr_i(rq_tri[AW-1:0]), .wdata_i({rq_x, rq_y, rq_z}), .raddr_i(raddr),
    .rdata_o(m_rd));

  // Sequence the scan
  always_comb begin
    st_d = st_q;
    n_d = n_q;
    rd_cnt_d = rd_cnt_q;
    case (st_q)
      StIdle: begin
        if (q_pop_o && rq_type == mpl_pkg::ReqQuery) begin
          n_d = (32'(active_q_i) > MaxTriangles) ? 17'(MaxTriangles) : 17'(active_q_i);
          rd_cnt_d = 17'd0;
          st_d = StScan;
        end
      end
      StScan: begin
        if (rd_cnt_q >= n_q) st_d = StDrain;
        else rd_cnt_d = rd_cnt_q + 17'd1;
      end
      StDrain: begin
        if (!s1_v_q && !s2_v_q && !s3_v_q && !s4_v_q) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  logic last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      n_q <= '0;
      rd_cnt_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      st_q <= st_d;
      n_q <= n_d;
      rd_cnt_q <= rd_cnt_d;
      s1_v_q <= (st_q == StScan) && (rd_cnt_q < n_q);
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      last_q <= (st_q == StDrain) && !s1_v_q && !s2_v_q && !s3_v_q && !s4_v_q;
    end
  end

  // Hold query point and stage indexes
  always_ff @(posedge clk_i) begin
    if (q_pop_o && rq_type == mpl_pkg::ReqQuery) begin
      px_q <= rq_x;
      py_q <= rq_y;
      pz_q <= rq_z;
    end
    s1_i_q <= raddr;
    s2_i_q <= s1_i_q;
    s3_i_q <= s2_i_q;
    s4_i_q <= s3_i_q;
  end

  // Stage 1: differences from RAM outputs
  logic signed [C-1:0] ax, az, bx, bz, cx, cz, mx, my, mz;
  assign {ax, az} = v0_rd;
  assign {bx, bz} = v1_rd;
  assign {cx, cz} = v2_rd;
  assign {mx, my, mz} = m_rd;

  function automatic logic signed [DW-1:0] df(logic signed [C-1:0] a, logic signed [C-1:0] b);
    df = DW'(a) - DW'(b);
  endfunction
  function automatic logic [C:0] ad(logic signed [C-1:0] a, logic signed [C-1:0] b);
    logic signed [C:0] d;
    d = (C+1)'(a) - (C+1)'(b);
    ad = d[C] ? (C+1)'(-d) : (C+1)'(d);
  endfunction

  logic signed [DW-1:0] d_q [10];
  logic [C:0] dy_q, ex_q, ez_q;
  always_ff @(posedge clk_i) begin
    // full triangle: (b-a)x(c-a)
    d_q[0] <= df(bx, ax); d_q[1] <= df(cz, az); d_q[2] <= df(cx, ax); d_q[3] <= df(bz, az);
    // (p,b,c)
    d_q[4] <= df(bx, px_q); d_q[5] <= df(cz, pz_q); d_q[6] <= df(cx, px_q);
    d_q[7] <= df(bz, pz_q);
    // (a,p,c): (p-a)x(c-a) uses d[1],d[2]
    d_q[8] <= df(px_q, ax); d_q[9] <= df(pz_q, az);
    // (a,b,p): (b-a)x(p-a) uses d[0],d[3],d[8],d[9]
    dy_q <= ad(py_q, my);
    ex_q <= ad(px_q, mx);
    ez_q <= ad(pz_q, mz);
  end

  // Stage 2: products
  logic signed [PW-1:0] p_q [8];
  logic [QW-1:0] sq_q;
  logic [C:0] dy2_q;
  logic [2*C+1:0] sqx, sqy, sqz;
  assign sqx = ex_q * ex_q;
  assign sqy = dy_q * dy_q;
  assign sqz = ez_q * ez_q;
  always_ff @(posedge clk_i) begin
    p_q[0] <= d_q[0] * d_q[1];
    p_q[1] <= d_q[2] * d_q[3];
    p_q[2] <= d_q[4] * d_q[5];
    p_q[3] <= d_q[6] * d_q[7];
    p_q[4] <= d_q[8] * d_q[1];
    p_q[5] <= d_q[2] * d_q[9];
    p_q[6] <= d_q[0] * d_q[9];
    p_q[7] <= d_q[8] * d_q[3];
    sq_q <= QW'(sqx) + QW'(sqy) + QW'(sqz);
    dy2_q <= dy_q;
  end

  function automatic logic [SW-1:0] ab(logic signed [PW-1:0] p, logic signed [PW-1:0] q);
    logic signed [PW:0] d;
    d = (PW+1)'(p) - (PW+1)'(q);
    ab = d[PW] ? SW'(-d) : SW'(d);
  endfunction

  // Stage 3: areas
  logic [SW-1:0] area_q, ssum_q;
  logic [C:0]    dy3_q;
  logic [QW-1:0] sq3_q;
  always_ff @(posedge clk_i) begin
    area_q <= ab(p_q[0], p_q[1]);
    ssum_q <= ab(p_q[2], p_q[3]) + ab(p_q[4], p_q[5]) + ab(p_q[6], p_q[7]);
    dy3_q  <= dy2_q;
    sq3_q  <= sq_q;
  end

  // Stage 4: tolerance and containment test
  logic [SW-1:0] tol, lo;
  logic          hit;
  always_comb begin
    tol = (area_q * SW'(mpl_pkg::TolMul)) >> mpl_pkg::TolShift;
    lo  = (area_q >= tol) ? area_q - tol : '0;
    hit = (ssum_q >= lo) && (ssum_q <= area_q + tol);
  end

  // Running selection
  logic          in_f_q, nr_f_q;
  logic [AW-1:0] in_i_q, nr_i_q;
  logic [C:0]    by_q;
  logic [QW-1:0] bd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_f_q <= 1'b0;
      nr_f_q <= 1'b0;
      in_i_q <= '0;
      nr_i_q <= '0;
      by_q <= '0;
      bd_q <= '0;
    end else if (st_q == StIdle && st_d == StScan) begin
      in_f_q <= 1'b0;
      nr_f_q <= 1'b0;
      in_i_q <= '0;
      nr_i_q <= '0;
    end else if (s4_v_q) begin
      if (hit && (!in_f_q || dy3_q < by_q)) begin
        in_f_q <= 1'b1;
        by_q <= dy3_q;
        in_i_q <= s4_i_q;
      end
      if (!nr_f_q || sq3_q < bd_q) begin
        nr_f_q <= 1'b1;
        bd_q <= sq3_q;
        nr_i_q <= s4_i_q;
      end
    end
  end

  assign done_o          = last_q;
  assign inside_found_o  = in_f_q;
  assign inside_index_o  = 8'(in_i_q);
  assign nearest_found_o = nr_f_q;
  assign nearest_index_o = 8'(nr_i_q);
endmodule

/* design/mesh_point_locator_top.sv */
// Top level of the mesh point locator.
// Usage: raise start with a request (req_type_i, tri_index_i, corner_i,
// pos_*_i); it is taken at a clock edge where busy is low. A load writes a
// vertex (x, z) or the middle point (x, y, z) of triangle tri_index_i and
// gives no result. A query scans n = min(active_triangles, MaxTriangles)
// entries, one a cycle through the triangle RAMs, and returns one result
// with done_o high for a single cycle: inside_found_o/inside_index_o and
// nearest_found_o/nearest_index_o.
// Requests pass through a two-entry queue, so busy rises only when it is
// full. A load holds the back end only while it is taken; a query holds it
// through the one-read-port table scan and the four-stage arithmetic
// pipeline behind it, until its result is shown.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Write active_triangles through cfg_we_i/cfg_wdata_i only while idle.
// Reset clears the queue, sequencer and register; triangle storage holds
// undefined data until loaded.
module mesh_point_locator_top #(
  parameter int unsigned MaxTriangles = mpl_pkg::MaxTriangles,
  parameter int unsigned CoordBits    = mpl_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [7:0]                  tri_index_i,
  input  logic [1:0]                  corner_i,
  input  logic [CoordBits-1:0]        pos_x_i,
  input  logic [CoordBits-1:0]        pos_y_i,
  input  logic [CoordBits-1:0]        pos_z_i,
  input  logic                        cfg_we_i,
  input  logic [mpl_pkg::CntBits-1:0] cfg_wdata_i,
  output logic                        done_o,
  output logic                        inside_found_o,
  output logic [7:0]                  inside_index_o,
  output logic                        nearest_found_o,
  output logic [7:0]                  nearest_index_o
);
  logic [mpl_pkg::CntBits-1:0] active_q;
  logic                        q_valid, q_pop;
  logic [3*CoordBits+10:0]     q_data;

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= '0;
    else if (cfg_we_i) active_q <= cfg_wdata_i;
  end

  mpl_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .req_type_i, .tri_index_i,
    .corner_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data));

  mpl_back #(.MaxTriangles(MaxTriangles), .CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .active_q_i(active_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_data_i(q_data), .done_o, .inside_found_o, .inside_index_o,
    .nearest_found_o, .nearest_index_o);

  // A result never comes on consecutive cycles
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done pulse too long");
  // A containing triangle implies an active one
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inside_found_o |-> nearest_found_o) else $error("inside without nearest");
  // Queue never pops while empty
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
endmodule

/* tb/mpl_checker.sv */
// Request and result monitor for the mesh point locator, with a prediction of every result.
module mpl_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        req_type_i,
  input  logic [7:0]  tri_index_i,
  input  logic [1:0]  corner_i,
  input  logic [23:0] pos_x_i,
  input  logic [23:0] pos_y_i,
  input  logic [23:0] pos_z_i,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        done_o,
  input  logic        inside_found_o,
  input  logic [7:0]  inside_index_o,
  input  logic        nearest_found_o,
  input  logic [7:0]  nearest_index_o,
  output int          errors_o,
  output int          pending_o
);
  typedef struct packed {
    logic       in_found;
    logic [7:0] in_idx;
    logic       nr_found;
    logic [7:0] nr_idx;
  } locate_t;

  // Own copy of the triangle table and the scan length
  longint   vtx_x [mpl_pkg::MaxTriangles*3];
  longint   vtx_z [mpl_pkg::MaxTriangles*3];
  longint   mid_x [mpl_pkg::MaxTriangles];
  longint   mid_y [mpl_pkg::MaxTriangles];
  longint   mid_z [mpl_pkg::MaxTriangles];
  logic [8:0] scan_len;
  locate_t  located_q [$];
  int       errors;
  int       pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  // Doubled area in the x-z plane
  function automatic longint tri_area2(longint ax, longint az, longint bx, longint bz,
                                       longint cx, longint cz);
    longint d;
    d = (bx - ax) * (cz - az) - (cx - ax) * (bz - az);
    return (d < 0) ? -d : d;
  endfunction

  function automatic longint absd(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic locate_t locate(longint px, longint py, longint pz);
    locate_t r;
    longint a, s, tol, lo, dy, d, best_y, best_d;
    int n;
    r = '0;
    best_y = 0;
    best_d = 0;
    n = (scan_len > mpl_pkg::MaxTriangles) ? int'(mpl_pkg::MaxTriangles) : int'(scan_len);
    for (int t = 0; t < n; t++) begin
      a = tri_area2(vtx_x[t*3], vtx_z[t*3], vtx_x[t*3+1], vtx_z[t*3+1],
                    vtx_x[t*3+2], vtx_z[t*3+2]);
      s = tri_area2(px, pz, vtx_x[t*3+1], vtx_z[t*3+1], vtx_x[t*3+2], vtx_z[t*3+2])
        + tri_area2(vtx_x[t*3], vtx_z[t*3], px, pz, vtx_x[t*3+2], vtx_z[t*3+2])
        + tri_area2(vtx_x[t*3], vtx_z[t*3], vtx_x[t*3+1], vtx_z[t*3+1], px, pz);
      tol = (a >>> mpl_pkg::TolShift) * mpl_pkg::TolMul
          + (((a & 64'h1FFF) * mpl_pkg::TolMul) >>> mpl_pkg::TolShift);
      lo = (a >= tol) ? a - tol : 0;
      if (s >= lo && s <= a + tol) begin
        dy = absd(py, mid_y[t]);
        if (!r.in_found || dy < best_y) begin
          r.in_found = 1'b1;
          r.in_idx   = t[7:0];
          best_y     = dy;
        end
      end
      d = absd(px, mid_x[t]) ** 2 + absd(py, mid_y[t]) ** 2 + absd(pz, mid_z[t]) ** 2;
      if (!r.nr_found || d < best_d) begin
        r.nr_found = 1'b1;
        r.nr_idx   = t[7:0];
        best_d     = d;
      end
    end
    return r;
  endfunction

  // Follow requests, register writes and results
  always @(posedge clk_i or negedge rst_ni) begin
    locate_t got, want;
    longint px, py, pz;
    if (!rst_ni) begin
      scan_len <= '0;
      errors   <= 0;
      pending  <= 0;
      located_q.delete();
    end else begin
      if (cfg_we_i) scan_len <= cfg_wdata_i;
      if (start && !busy) begin
        px = longint'(signed'(pos_x_i));
        py = longint'(signed'(pos_y_i));
        pz = longint'(signed'(pos_z_i));
        if (req_type_i == mpl_pkg::ReqLoad) begin
          if (corner_i == mpl_pkg::CornerMid) begin
            mid_x[tri_index_i] = px;
            mid_y[tri_index_i] = py;
            mid_z[tri_index_i] = pz;
          end else begin
            vtx_x[tri_index_i*3 + corner_i] = px;
            vtx_z[tri_index_i*3 + corner_i] = pz;
          end
        end else begin
          located_q.insert(located_q.size(), locate(px, py, pz));
        end
      end
      if (done_o) begin
        got = {inside_found_o, inside_index_o, nearest_found_o, nearest_index_o};
        if (located_q.size() == 0) begin
          if (errors < 10) $display("result with no pending request: %p", got);
          errors <= errors + 1;
        end else begin
          want = located_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: expected in %0d/%0d nr %0d/%0d, got in %0d/%0d nr %0d/%0d",
                       want.in_found, want.in_idx, want.nr_found, want.nr_idx,
                       got.in_found, got.in_idx, got.nr_found, got.nr_idx);
            errors <= errors + 1;
          end
        end
      end
      pending <= located_q.size();
    end
  end
endmodule

/* tb/tb.sv */
// Stimulus and verdict for the mesh point locator.
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type_i = mpl_pkg::ReqLoad;
  logic [7:0]  tri_index_i = '0;
  logic [1:0]  corner_i = '0;
  logic [23:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        done_o, inside_found_o, nearest_found_o;
  logic [7:0]  inside_index_o, nearest_index_o;
  int          errors, pending;
  int          quiet;
  bit          bursts_on = 1'b1;

  // Stimulus-side view of the table geometry
  int tv_x [256][3];
  int tv_z [256][3];
  int tm_x [256];
  int tm_y [256];
  int tm_z [256];

  mesh_point_locator_top dut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .tri_index_i, .corner_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .cfg_we_i, .cfg_wdata_i, .done_o,
    .inside_found_o, .inside_index_o, .nearest_found_o, .nearest_index_o
  );

  mpl_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .tri_index_i, .corner_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .cfg_we_i, .cfg_wdata_i, .done_o,
    .inside_found_o, .inside_index_o, .nearest_found_o, .nearest_index_o,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 6000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int srand(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // Present one request and hold it until taken
  task automatic send(logic kind, int t, int c, int x, int y, int z);
    int gap;
    gap = (bursts_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    req_type_i  <= kind;
    tri_index_i <= t[7:0];
    corner_i    <= c[1:0];
    pos_x_i     <= x[23:0];
    pos_y_i     <= y[23:0];
    pos_z_i     <= z[23:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic load_pt(int t, int c, int x, int y, int z);
    if (c == mpl_pkg::CornerMid) begin
      tm_x[t] = x; tm_y[t] = y; tm_z[t] = z;
    end else begin
      tv_x[t][c] = x; tv_z[t][c] = z;
    end
    send(mpl_pkg::ReqLoad, t, c, x, y, z);
  endtask

  task automatic query(int x, int y, int z);
    send(mpl_pkg::ReqQuery, $urandom_range(0, 255), $urandom_range(0, 3), x, y, z);
  endtask

  // Drain outstanding results, let a trailing load finish, then write the register
  task automatic set_active(int n);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load a random triangle, corners in rotated order; now and then a copy of its neighbour
  task automatic make_tri(int t);
    int s, cx, cz, r, c;
    int px [4];
    int pz [4];
    int py [4];
    case ($urandom_range(0, 3))
      0: s = 64;
      1: s = 4096;
      2: s = 1 << 20;
      default: s = 1 << 23;
    endcase
    cx = (s == (1 << 23)) ? 0 : srand(1 << 22);
    cz = (s == (1 << 23)) ? 0 : srand(1 << 22);
    for (int k = 0; k < 3; k++) begin
      px[k] = cx + srand(s); pz[k] = cz + srand(s); py[k] = $urandom;
    end
    px[3] = (px[0] + px[1] + px[2]) / 3;
    pz[3] = (pz[0] + pz[1] + pz[2]) / 3;
    py[3] = srand(1 << 20);
    if (t > 0 && $urandom_range(0, 7) == 0) begin
      for (int k = 0; k < 3; k++) begin
        px[k] = tv_x[t-1][k]; pz[k] = tv_z[t-1][k];
      end
      px[3] = tm_x[t-1]; py[3] = tm_y[t-1]; pz[3] = tm_z[t-1];
    end
    r = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      c = (k + r) % 4;
      load_pt(t, c, px[c], py[c], pz[c]);
    end
  endtask

  // Query a point placed relative to triangle t
  task automatic query_near(int t);
    int x, y, z, a, b;
    a = $urandom_range(0, 2);
    b = (a + 1) % 3;
    case ($urandom_range(0, 5))
      0: begin
        x = (tv_x[t][0] + tv_x[t][1] + tv_x[t][2]) / 3;
        z = (tv_z[t][0] + tv_z[t][1] + tv_z[t][2]) / 3;
      end
      1: begin x = tv_x[t][a]; z = tv_z[t][a]; end
      2: begin x = (tv_x[t][a] + tv_x[t][b]) / 2; z = (tv_z[t][a] + tv_z[t][b]) / 2; end
      3: begin x = tm_x[t] + srand(256); z = tm_z[t] + srand(256); end
      4: begin x = tm_x[t] + srand(1 << 16); z = tm_z[t] + srand(1 << 16); end
      default: begin x = $urandom; z = $urandom; end
    endcase
    y = ($urandom_range(0, 4) == 0) ? int'($urandom) : tm_y[t] + srand(1 << 12);
    query(x, y, z);
  endtask

  initial begin
    int n, q;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty scan, extreme query points
    set_active(0);
    query(32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF);
    query(32'hFF80_0000, 32'hFF80_0000, 32'hFF80_0000);
    // Full-range triangle, an identical twin for ties, and a degenerate one
    for (int t = 0; t < 2; t++) begin
      load_pt(t, 0, -8388608, 8388607, -8388608);
      load_pt(t, 1, 8388607, -8388608, -8388608);
      load_pt(t, 2, -8388608, 0, 8388607);
      load_pt(t, 3, 0, 8388607, 0);
    end
    for (int c = 0; c < 3; c++) load_pt(2, c, 0, c, 0);
    load_pt(2, 3, -8388608, -8388608, -8388608);
    set_active(3);
    query(-100000, 5, -100000);
    query(-8388608, 0, -8388608);
    query(8388607, 8388607, 8388607);
    query(0, -8388608, 0);
    query(0, 0, 8388607);

    // Fill the whole table; idling stops for the last part of the run
    for (int t = 0; t < 256; t++) begin
      if (t == 192) bursts_on = 1'b0;
      make_tri(t);
    end

    // Query phases under several register values, with stray reloads
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: n = $urandom_range(1, 16);
        1: n = $urandom_range(17, 255);
        default: n = 256;
      endcase
      set_active(n);
      q = $urandom_range(5, 8);
      for (int i = 0; i < q; i++) begin
        if ($urandom_range(0, 6) == 0)
          load_pt($urandom_range(0, n - 1), $urandom_range(0, 3),
                  srand(1 << 22), $urandom, srand(1 << 22));
        else if ($urandom_range(0, 9) == 0)
          query($urandom, $urandom, $urandom);
        else
          query_near($urandom_range(0, n - 1));
      end
    end

    // Register above the table size saturates
    set_active(511);
    for (int i = 0; i < 4; i++) query_near($urandom_range(0, 255));
    set_active(300);
    for (int i = 0; i < 3; i++) query($urandom, $urandom, $urandom);
    set_active(0);
    query(1, 2, 3);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* files.f */
design/mpl_pkg.sv
design/mpl_ram.sv
design/mpl_front.sv
design/mpl_back.sv
design/mesh_point_locator_top.sv
tb/mpl_checker.sv
tb/tb.sv
